FILE: rtl/belt_pkg.sv
// ============================================================================
// BelT block cipher package
// Shared types, the S-box and the keyed G function of the BelT cipher.
// ============================================================================
package belt_pkg;

    localparam int NUM_ROUNDS       = 8;
    localparam int NUM_KEY_WORDS    = 8;
    localparam int KEY_IDX_W        = 3;
    localparam int STAGES_PER_ROUND = 4;
    localparam int NUM_STAGES       = NUM_ROUNDS * STAGES_PER_ROUND;
    localparam int G_PER_ROUND      = 7;

    // rotate amounts used by the G function
    localparam logic [4:0] ROT_5  = 5'd5;
    localparam logic [4:0] ROT_13 = 5'd13;
    localparam logic [4:0] ROT_21 = 5'd21;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_blk;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hB1, 8'h94, 8'hBA, 8'hC8, 8'h0A, 8'h08, 8'hF5, 8'h3B,
        8'h36, 8'h6D, 8'h00, 8'h8E, 8'h58, 8'h4A, 8'h5D, 8'hE4,
        8'h85, 8'h04, 8'hFA, 8'h9D, 8'h1B, 8'hB6, 8'hC7, 8'hAC,
        8'h25, 8'h2E, 8'h72, 8'hC2, 8'h02, 8'hFD, 8'hCE, 8'h0D,
        8'h5B, 8'hE3, 8'hD6, 8'h12, 8'h17, 8'hB9, 8'h61, 8'h81,
        8'hFE, 8'h67, 8'h86, 8'hAD, 8'h71, 8'h6B, 8'h89, 8'h0B,
        8'h5C, 8'hB0, 8'hC0, 8'hFF, 8'h33, 8'hC3, 8'h56, 8'hB8,
        8'h35, 8'hC4, 8'h05, 8'hAE, 8'hD8, 8'hE0, 8'h7F, 8'h99,
        8'hE1, 8'h2B, 8'hDC, 8'h1A, 8'hE2, 8'h82, 8'h57, 8'hEC,
        8'h70, 8'h3F, 8'hCC, 8'hF0, 8'h95, 8'hEE, 8'h8D, 8'hF1,
        8'hC1, 8'hAB, 8'h76, 8'h38, 8'h9F, 8'hE6, 8'h78, 8'hCA,
        8'hF7, 8'hC6, 8'hF8, 8'h60, 8'hD5, 8'hBB, 8'h9C, 8'h4F,
        8'hF3, 8'h3C, 8'h65, 8'h7B, 8'h63, 8'h7C, 8'h30, 8'h6A,
        8'hDD, 8'h4E, 8'hA7, 8'h79, 8'h9E, 8'hB2, 8'h3D, 8'h31,
        8'h3E, 8'h98, 8'hB5, 8'h6E, 8'h27, 8'hD3, 8'hBC, 8'hCF,
        8'h59, 8'h1E, 8'h18, 8'h1F, 8'h4C, 8'h5A, 8'hB7, 8'h93,
        8'hE9, 8'hDE, 8'hE7, 8'h2C, 8'h8F, 8'h0C, 8'h0F, 8'hA6,
        8'h2D, 8'hDB, 8'h49, 8'hF4, 8'h6F, 8'h73, 8'h96, 8'h47,
        8'h06, 8'h07, 8'h53, 8'h16, 8'hED, 8'h24, 8'h7A, 8'h37,
        8'h39, 8'hCB, 8'hA3, 8'h83, 8'h03, 8'hA9, 8'h8B, 8'hF6,
        8'h92, 8'hBD, 8'h9B, 8'h1C, 8'hE5, 8'hD1, 8'h41, 8'h01,
        8'h54, 8'h45, 8'hFB, 8'hC9, 8'h5E, 8'h4D, 8'h0E, 8'hF2,
        8'h68, 8'h20, 8'h80, 8'hAA, 8'h22, 8'h7D, 8'h64, 8'h2F,
        8'h26, 8'h87, 8'hF9, 8'h34, 8'h90, 8'h40, 8'h55, 8'h11,
        8'hBE, 8'h32, 8'h97, 8'h13, 8'h43, 8'hFC, 8'h9A, 8'h48,
        8'hA0, 8'h2A, 8'h88, 8'h5F, 8'h19, 8'h4B, 8'h09, 8'hA1,
        8'h7E, 8'hCD, 8'hA4, 8'hD0, 8'h15, 8'h44, 8'hAF, 8'h8C,
        8'hA5, 8'h84, 8'h50, 8'hBF, 8'h66, 8'hD2, 8'hE8, 8'h8A,
        8'hA2, 8'hD7, 8'h46, 8'h52, 8'h42, 8'hA8, 8'hDF, 8'hB3,
        8'h69, 8'h74, 8'hC5, 8'h51, 8'hEB, 8'h23, 8'h29, 8'h21,
        8'hD4, 8'hEF, 8'hD9, 8'hB4, 8'h3A, 8'h62, 8'h28, 8'h75,
        8'h91, 8'h14, 8'h10, 8'hEA, 8'h77, 8'h6C, 8'hDA, 8'h1D
    };

    // key add, byte-wise S-box, rotate left
    function automatic logic [31:0] belt_g(
        input logic [31:0] v,
        input logic [31:0] k,
        input logic [4:0]  rot
    );
        logic [31:0] w;
        logic [31:0] s;
        logic [63:0] dbl;
        w   = v + k;
        s   = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
        dbl = {s, s} << rot;
        return dbl[63:32];
    endfunction

endpackage

FILE: rtl/belt_block_encrypt.sv
// ============================================================================
// BelT block encryption
// Fully unrolled BelT encryption pipeline, 32 stages, with output skid stage.
// ============================================================================
// An accepted item moves through the stage registers in order to the output.
// Throughput: one item per cycle while the skid stage is empty; each of the 8
//   rounds spans 4 register stages of one G level each; depth sets fmax.
// A stalled result parks in the skid stage, and the pipeline holds meanwhile.
// Reset: synchronous, active low; clears all valid bits, the skid flag and
//   the eight key words (all-zero key after reset).
module belt_block_encrypt
    import belt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // key configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    // plaintext items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_in_word_0,
    input  logic [31:0] i_in_word_1,
    input  logic [31:0] i_in_word_2,
    input  logic [31:0] i_in_word_3,

    // ciphertext items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word_0,
    output logic [31:0] o_out_word_1,
    output logic [31:0] o_out_word_2,
    output logic [31:0] o_out_word_3
);

    localparam int LAST = NUM_STAGES - 1;

    // key words; user must write only while pipeline is empty (not enforced)
    logic [31:0]           r_key [NUM_KEY_WORDS];

    // pipeline stage registers and their valid bits
    t_blk                  r_blk [NUM_STAGES];
    logic [LAST:0]         r_vld;
    t_blk                  w_stg_in [NUM_STAGES];
    t_blk                  n_blk [NUM_STAGES];

    // skid stage behind the last pipeline stage
    t_blk                  r_skid;
    logic                  r_skid_vld;

    logic                  w_adv;
    logic                  w_skid_load;
    t_blk                  w_out;

    // The whole pipeline moves as one while the skid stage is empty. A result
    // that the sink does not take is parked in the skid stage, so one more
    // item is taken in before the pipeline holds.
    assign w_adv       = !r_skid_vld;
    assign o_in_ready  = w_adv;
    assign w_skid_load = !r_skid_vld && r_vld[LAST] && !i_out_ready;

    assign w_stg_in[0] = '{a: i_in_word_0, b: i_in_word_1, c: i_in_word_2, d: i_in_word_3};

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int RND = s / STAGES_PER_ROUND;
        localparam int PH  = s % STAGES_PER_ROUND;
        localparam int KB  = G_PER_ROUND * RND;
        localparam logic [31:0] RC = 32'(RND + 1);

        if (s > 0) begin : g_link
            assign w_stg_in[s] = r_blk[s-1];
        end

        if (PH == 0) begin : g_ph0
            // b ^= G(a), c ^= G(d)
            localparam int K0 = (KB + 0) % NUM_KEY_WORDS;
            localparam int K1 = (KB + 1) % NUM_KEY_WORDS;
            always_comb begin
                n_blk[s]   = w_stg_in[s];
                n_blk[s].b = w_stg_in[s].b ^
                             belt_g(w_stg_in[s].a, r_key[K0[KEY_IDX_W-1:0]], ROT_5);
                n_blk[s].c = w_stg_in[s].c ^
                             belt_g(w_stg_in[s].d, r_key[K1[KEY_IDX_W-1:0]], ROT_21);
            end
        end else if (PH == 1) begin : g_ph1
            // a -= G(b); mix b and c through e = G(b + c) ^ round number
            localparam int K2 = (KB + 2) % NUM_KEY_WORDS;
            localparam int K3 = (KB + 3) % NUM_KEY_WORDS;
            logic [31:0] w_e;
            assign w_e = belt_g(w_stg_in[s].b + w_stg_in[s].c,
                                r_key[K3[KEY_IDX_W-1:0]], ROT_21) ^ RC;
            always_comb begin
                n_blk[s]   = w_stg_in[s];
                n_blk[s].a = w_stg_in[s].a -
                             belt_g(w_stg_in[s].b, r_key[K2[KEY_IDX_W-1:0]], ROT_13);
                n_blk[s].b = w_stg_in[s].b + w_e;
                n_blk[s].c = w_stg_in[s].c - w_e;
            end
        end else if (PH == 2) begin : g_ph2
            // d += G(c)
            localparam int K4 = (KB + 4) % NUM_KEY_WORDS;
            always_comb begin
                n_blk[s]   = w_stg_in[s];
                n_blk[s].d = w_stg_in[s].d +
                             belt_g(w_stg_in[s].c, r_key[K4[KEY_IDX_W-1:0]], ROT_13);
            end
        end else begin : g_ph3
            // b ^= G(a), c ^= G(d), then the word swaps of the round end
            localparam int K5 = (KB + 5) % NUM_KEY_WORDS;
            localparam int K6 = (KB + 6) % NUM_KEY_WORDS;
            always_comb begin
                n_blk[s].a = w_stg_in[s].b ^
                             belt_g(w_stg_in[s].a, r_key[K5[KEY_IDX_W-1:0]], ROT_21);
                n_blk[s].b = w_stg_in[s].d;
                n_blk[s].c = w_stg_in[s].a;
                n_blk[s].d = w_stg_in[s].c ^
                             belt_g(w_stg_in[s].d, r_key[K6[KEY_IDX_W-1:0]], ROT_5);
            end
        end
    end

    // control state: valid bits, skid flag, key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
            for (int i = 0; i < NUM_KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[LAST-1:0], i_in_valid};
            end
            if (r_skid_vld) begin
                if (i_out_ready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (w_skid_load) begin
                r_skid_vld <= 1'b1;
            end
            if (i_cfg_we) begin
                r_key[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // payload: advance all stages together, park a stalled result
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_blk[i] <= n_blk[i];
            end
        end
        if (w_skid_load) begin
            r_skid <= r_blk[LAST];
        end
    end

    // the skid stage holds the older item, so it goes first
    assign w_out        = r_skid_vld ? r_skid : r_blk[LAST];
    assign o_out_valid  = r_skid_vld || r_vld[LAST];
    assign o_out_word_0 = w_out.b;
    assign o_out_word_1 = w_out.d;
    assign o_out_word_2 = w_out.a;
    assign o_out_word_3 = w_out.c;

    // an item accepted at the input lands in the first stage
    a_in_to_stage0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted item missing from first stage");

    // an item in the first stage moves on whenever the pipeline advances
    a_stage_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[0] |=> r_vld[1])
        else $error("item lost between stages");

    // a full skid stage freezes every valid bit of the pipeline
    a_hold_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r_vld))
        else $error("pipeline moved while skid stage full");

    // a parked result that is not taken is neither dropped nor overwritten
    a_skid_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_out_ready |=> r_skid_vld && $stable(r_skid))
        else $error("parked result lost");

endmodule
